### hdl/box_duplicate_window_filter_top_defines.svh
// Assertion macros shared by the duplicate window filter modules.
// With SYNTHESIS defined, every macro expands to nothing.
`ifndef BOX_DUPLICATE_WINDOW_FILTER_TOP_DEFINES_SVH
`define BOX_DUPLICATE_WINDOW_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define BDWF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property violated");

`define BDWF_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define BDWF_ASSERT(label, clk, rst_n, prop)

`define BDWF_NEVER(label, clk, rst_n, expr)

`endif

`endif

### hdl/bdwf_pkg.sv
package bdwf_pkg;

    localparam int MAX_LOOKAHEAD = 16;
    localparam int COORD_BITS    = 16;
    localparam int TAG_BITS      = 16;
    localparam int CNT_BITS      = 16;
    localparam int TOL_BITS      = 16;
    localparam int LOOK_BITS     = 5;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_BITS      = 16;

    localparam int WIN_SLOTS = MAX_LOOKAHEAD + 1;
    localparam int FILL_BITS = $clog2(WIN_SLOTS + 1);
    localparam int WIDE_BITS = ((FILL_BITS > LOOK_BITS) ? FILL_BITS : LOOK_BITS) + 1;
    localparam int DIFF_BITS = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;
    localparam int HIT_BITS  = $clog2(WIN_SLOTS + 1);

    localparam logic [TOL_BITS-1:0]  TOL_RESET  = TOL_BITS'(7);
    localparam logic [LOOK_BITS-1:0] LOOK_RESET = LOOK_BITS'(10);
    localparam logic [CNT_BITS-1:0]  CNT_MAX    = {CNT_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_TOLERANCE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOOKAHEAD       = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [TAG_BITS-1:0]   tag;
    } box_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_MATCH,
        S_COUNT,
        S_FLUSH,
        S_TRIM
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic pop;
        logic pop_final;
        logic match;
        logic count;
        logic clear_list;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic over_lim;
        logic fill_one;
        logic out_free;
        logic eol;
    } status_t;

    function automatic logic coord_close(input logic [COORD_BITS-1:0] a,
                                         input logic [COORD_BITS-1:0] b,
                                         input logic [TOL_BITS-1:0]   tol);
        logic [COORD_BITS-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return DIFF_BITS'(d) < DIFF_BITS'(tol);
    endfunction

endpackage

### hdl/bdwf_datapath.sv
`include "box_duplicate_window_filter_top_defines.svh"

module bdwf_datapath
    import bdwf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  box_t                    in_box,
    input  logic                    in_eol,
    input  cmd_t                    cmd,
    output status_t                 st,
    input  logic                    out_stall,
    output logic                    out_valid,
    output box_t                    out_box,
    output logic                    out_keep,
    output logic                    out_final,
    output logic [CNT_BITS-1:0]     out_count
);

    logic [TOL_BITS-1:0]  tol_reg, tol_next;
    logic [LOOK_BITS-1:0] look_reg, look_next;
    logic [WIDE_BITS-1:0] lim;

    box_t                 in_box_reg, in_box_next;
    logic                 eol_reg, eol_next;

    box_t                 win_reg  [WIN_SLOTS];
    box_t                 win_next [WIN_SLOTS];
    logic [WIN_SLOTS-1:0] mark_reg, mark_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [WIN_SLOTS-1:0] hit_vec;
    logic [WIN_SLOTS-1:0] hit_reg, hit_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [CNT_BITS:0]    cnt_sum;

    logic                 out_valid_reg, out_valid_next;
    box_t                 out_box_reg, out_box_next;
    logic                 out_keep_reg, out_keep_next;
    logic                 out_final_reg, out_final_next;
    logic [CNT_BITS-1:0]  out_count_reg, out_count_next;

    always_comb
    begin
        tol_next  = tol_reg;
        look_next = look_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MATCH_TOLERANCE: tol_next  = cfg_data[TOL_BITS-1:0];
                CFG_LOOKAHEAD:       look_next = cfg_data[LOOK_BITS-1:0];
                default:             tol_next  = tol_reg;
            endcase
        end
    end

    assign lim = (WIDE_BITS'(look_reg) > WIDE_BITS'(MAX_LOOKAHEAD)) ?
                 WIDE_BITS'(MAX_LOOKAHEAD) : WIDE_BITS'(look_reg);

    assign in_box_next = cmd.load_in ? in_box : in_box_reg;
    assign eol_next    = cmd.load_in ? in_eol : eol_reg;

    // An entry takes part only if it is pending, still unmarked, and the new box
    // falls within the lookahead distance after it.
    always_comb
    begin
        for (int k = 0; k < WIN_SLOTS; k++)
        begin
            hit_vec[k] = (WIDE_BITS'(k) < WIDE_BITS'(fill_reg))
                       && (WIDE_BITS'(k) + lim >= WIDE_BITS'(fill_reg))
                       && !mark_reg[k]
                       && coord_close(win_reg[k].x, in_box_reg.x, tol_reg)
                       && coord_close(win_reg[k].y, in_box_reg.y, tol_reg)
                       && coord_close(win_reg[k].w, in_box_reg.w, tol_reg)
                       && coord_close(win_reg[k].h, in_box_reg.h, tol_reg);
        end
    end

    assign hit_next = cmd.match ? hit_vec : hit_reg;

    always_comb
    begin
        for (int k = 0; k < WIN_SLOTS; k++)
        begin
            win_next[k] = win_reg[k];
        end
        mark_next = mark_reg;
        fill_next = fill_reg;
        if (cmd.pop)
        begin
            for (int k = 0; k < WIN_SLOTS - 1; k++)
            begin
                win_next[k] = win_reg[k + 1];
            end
            mark_next = {1'b0, mark_reg[WIN_SLOTS-1:1]};
            fill_next = fill_reg - FILL_BITS'(1);
        end
        if (cmd.match)
        begin
            for (int k = 0; k < WIN_SLOTS; k++)
            begin
                if (FILL_BITS'(k) == fill_reg)
                begin
                    win_next[k] = in_box_reg;
                end
            end
            mark_next = mark_reg | hit_vec;
            fill_next = fill_reg + FILL_BITS'(1);
        end
        if (cmd.clear_list)
        begin
            mark_next = '0;
            fill_next = '0;
        end
    end

    assign cnt_sum = {1'b0, cnt_reg} + (CNT_BITS + 1)'(HIT_BITS'($countones(hit_reg)));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.count)
        begin
            cnt_next = cnt_sum[CNT_BITS] ? CNT_MAX : cnt_sum[CNT_BITS-1:0];
        end
        if (cmd.clear_list)
        begin
            cnt_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_box_next   = out_box_reg;
        out_keep_next  = out_keep_reg;
        out_final_next = out_final_reg;
        out_count_next = out_count_reg;
        if (cmd.pop)
        begin
            out_valid_next = 1'b1;
            out_box_next   = win_reg[0];
            out_keep_next  = !mark_reg[0];
            out_final_next = cmd.pop_final;
            out_count_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= TOL_RESET;
            look_reg      <= LOOK_RESET;
            mark_reg      <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tol_reg       <= tol_next;
            look_reg      <= look_next;
            mark_reg      <= mark_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_box_reg    <= in_box_next;
        eol_reg       <= eol_next;
        hit_reg       <= hit_next;
        out_box_reg   <= out_box_next;
        out_keep_reg  <= out_keep_next;
        out_final_reg <= out_final_next;
        out_count_reg <= out_count_next;
        for (int k = 0; k < WIN_SLOTS; k++)
        begin
            win_reg[k] <= win_next[k];
        end
    end

    assign st.over_lim = WIDE_BITS'(fill_reg) > lim;
    assign st.fill_one = fill_reg == FILL_BITS'(1);
    assign st.out_free = !out_valid_reg || !out_stall;
    assign st.eol      = eol_reg;

    assign out_valid = out_valid_reg;
    assign out_box   = out_box_reg;
    assign out_keep  = out_keep_reg;
    assign out_final = out_final_reg;
    assign out_count = out_count_reg;

    `BDWF_NEVER(a_fill_bound, clk, rst_n, WIDE_BITS'(fill_reg) > WIDE_BITS'(WIN_SLOTS))
    `BDWF_NEVER(a_pop_empty, clk, rst_n, cmd.pop && (fill_reg == '0))
    `BDWF_ASSERT(a_append_room, clk, rst_n,
                 cmd.match |-> (WIDE_BITS'(fill_reg) < WIDE_BITS'(WIN_SLOTS)))

endmodule

### hdl/bdwf_controller.sv
`include "box_duplicate_window_filter_top_defines.svh"

module bdwf_controller
    import bdwf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DRAIN;
                end
            end
            // Boxes beyond a lowered lookahead leave before the new box is compared.
            S_DRAIN:
            begin
                if (!st.over_lim)
                begin
                    state_next = S_MATCH;
                end
                else if (st.out_free)
                begin
                    cmd.pop = 1'b1;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = st.eol ? S_FLUSH : S_TRIM;
            end
            S_FLUSH:
            begin
                if (st.out_free)
                begin
                    cmd.pop       = 1'b1;
                    cmd.pop_final = st.fill_one;
                    if (st.fill_one)
                    begin
                        cmd.clear_list = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_TRIM:
            begin
                if (!st.over_lim)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BDWF_ASSERT(a_pop_needs_room, clk, rst_n, cmd.pop |-> st.out_free)
    `BDWF_ASSERT(a_count_branch, clk, rst_n,
                 (state_reg == S_COUNT) |=> (state_reg == S_FLUSH || state_reg == S_TRIM))
    `BDWF_ASSERT(a_clear_to_idle, clk, rst_n, cmd.clear_list |=> (state_reg == S_IDLE))

endmodule

### hdl/box_duplicate_window_filter_top.sv
//  Channel  Direction  Handshake             Payload
//  input    in         in_valid / in_stall   box_x, box_y, box_w, box_h, box_tag, end_of_list
//  output   out        out_valid / out_stall out_x .. out_tag, keep, final_result, duplicate_count
//  config   in         cfg_we                cfg_index, cfg_data
//
// One transaction is taken at a time. Boxes that a lowered lookahead pushes out leave
// first, and an item with end_of_list then flushes every result from the window.
// Each item follows the controller's sequence: drain, compare against all window
// slots in parallel, add the match count, then emit through a single output register.
// Reset clears window fill, duplicate marks, counter and out_valid; config takes its defaults.
// A stall on the output holds the result register and pauses the drain, trim and flush steps.

module box_duplicate_window_filter_top
    import bdwf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [COORD_BITS-1:0]   box_x,
    input  logic [COORD_BITS-1:0]   box_y,
    input  logic [COORD_BITS-1:0]   box_w,
    input  logic [COORD_BITS-1:0]   box_h,
    input  logic [TAG_BITS-1:0]     box_tag,
    input  logic                    end_of_list,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [COORD_BITS-1:0]   out_x,
    output logic [COORD_BITS-1:0]   out_y,
    output logic [COORD_BITS-1:0]   out_w,
    output logic [COORD_BITS-1:0]   out_h,
    output logic [TAG_BITS-1:0]     out_tag,
    output logic                    keep,
    output logic                    final_result,
    output logic [CNT_BITS-1:0]     duplicate_count
);

    cmd_t    cmd;
    status_t st;
    box_t    in_box;
    box_t    out_box;

    assign in_box.x   = box_x;
    assign in_box.y   = box_y;
    assign in_box.w   = box_w;
    assign in_box.h   = box_h;
    assign in_box.tag = box_tag;

    bdwf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    bdwf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_box    (in_box),
        .in_eol    (end_of_list),
        .cmd       (cmd),
        .st        (st),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_box   (out_box),
        .out_keep  (keep),
        .out_final (final_result),
        .out_count (duplicate_count)
    );

    assign out_x   = out_box.x;
    assign out_y   = out_box.y;
    assign out_w   = out_box.w;
    assign out_h   = out_box.h;
    assign out_tag = out_box.tag;

endmodule

### sim/bdwf_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts the resolved boxes
// and compares every output transaction against the oldest prediction.
module bdwf_checker
    import bdwf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [COORD_BITS-1:0]   box_x,
    input  logic [COORD_BITS-1:0]   box_y,
    input  logic [COORD_BITS-1:0]   box_w,
    input  logic [COORD_BITS-1:0]   box_h,
    input  logic [TAG_BITS-1:0]     box_tag,
    input  logic                    end_of_list,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [COORD_BITS-1:0]   out_x,
    input  logic [COORD_BITS-1:0]   out_y,
    input  logic [COORD_BITS-1:0]   out_w,
    input  logic [COORD_BITS-1:0]   out_h,
    input  logic [TAG_BITS-1:0]     out_tag,
    input  logic                    keep,
    input  logic                    final_result,
    input  logic [CNT_BITS-1:0]     duplicate_count,
    output int                      mismatches,
    output int                      results_due
);

    typedef struct packed {
        box_t                b;
        logic                keep;
        logic                fin;
        logic [CNT_BITS-1:0] cnt;
    } result_t;

    box_t                 m_win  [WIN_SLOTS];
    logic                 m_mark [WIN_SLOTS];
    int                   m_fill;
    int                   m_cnt;
    logic [TOL_BITS-1:0]  m_tol;
    logic [LOOK_BITS-1:0] m_look;
    result_t              exp_q [$];

    function automatic logic near(input logic [COORD_BITS-1:0] a,
                                  input logic [COORD_BITS-1:0] b);
        int d;
        d = (a > b) ? (int'(a) - int'(b)) : (int'(b) - int'(a));
        return d < int'(m_tol);
    endfunction

    task automatic pop_oldest(input logic fin);
        result_t r;
        r.b    = m_win[0];
        r.keep = !m_mark[0];
        r.fin  = fin;
        r.cnt  = CNT_BITS'(m_cnt);
        exp_q.push_back(r);
        for (int k = 1; k < m_fill; k++)
        begin
            m_win[k-1]  = m_win[k];
            m_mark[k-1] = m_mark[k];
        end
        if (m_fill > 0)
        begin
            m_fill--;
            m_mark[m_fill] = 1'b0;
        end
    endtask

    task automatic model_step(input box_t b, input logic eol);
        int lim;
        int n;
        lim = (int'(m_look) > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD : int'(m_look);
        while (m_fill > lim)
        begin
            pop_oldest(1'b0);
        end
        n = m_fill;
        for (int k = 0; k < n; k++)
        begin
            if ((n - k <= lim) && !m_mark[k] && near(m_win[k].x, b.x) &&
                near(m_win[k].y, b.y) && near(m_win[k].w, b.w) && near(m_win[k].h, b.h))
            begin
                m_mark[k] = 1'b1;
                if (m_cnt < int'(CNT_MAX))
                begin
                    m_cnt++;
                end
            end
        end
        if (n < WIN_SLOTS)
        begin
            m_win[n]  = b;
            m_mark[n] = 1'b0;
            m_fill    = n + 1;
        end
        if (eol)
        begin
            while (m_fill > 0)
            begin
                pop_oldest(m_fill == 1);
            end
            for (int k = 0; k < WIN_SLOTS; k++)
            begin
                m_mark[k] = 1'b0;
            end
            m_cnt = 0;
        end
        else
        begin
            while (m_fill > lim)
            begin
                pop_oldest(1'b0);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t act_r;
        box_t    in_b;
        if (!rst_n)
        begin
            m_tol  = TOL_RESET;
            m_look = LOOK_RESET;
            m_fill = 0;
            m_cnt  = 0;
            for (int k = 0; k < WIN_SLOTS; k++)
            begin
                m_mark[k] = 1'b0;
            end
            exp_q.delete();
            mismatches  = 0;
            results_due <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                act_r.b.x   = out_x;
                act_r.b.y   = out_y;
                act_r.b.w   = out_w;
                act_r.b.h   = out_h;
                act_r.b.tag = out_tag;
                act_r.keep  = keep;
                act_r.fin   = final_result;
                act_r.cnt   = duplicate_count;
                if (exp_q.size() == 0)
                begin
                    $display("%0t: expected no transaction, actual %h", $time, act_r);
                    mismatches++;
                end
                else
                begin
                    exp_r = exp_q.pop_front();
                    if (act_r !== exp_r)
                    begin
                        $display("%0t: expected %h, actual %h", $time, exp_r, act_r);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_MATCH_TOLERANCE)
                begin
                    m_tol = cfg_data[TOL_BITS-1:0];
                end
                else if (cfg_index == CFG_LOOKAHEAD)
                begin
                    m_look = cfg_data[LOOK_BITS-1:0];
                end
            end
            if (in_valid && !in_stall)
            begin
                in_b.x   = box_x;
                in_b.y   = box_y;
                in_b.w   = box_w;
                in_b.h   = box_h;
                in_b.tag = box_tag;
                model_step(in_b, end_of_list);
            end
            results_due <= exp_q.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bdwf_pkg::*;

    localparam int N_ITEMS = 160;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [COORD_BITS-1:0]   box_x;
    logic [COORD_BITS-1:0]   box_y;
    logic [COORD_BITS-1:0]   box_w;
    logic [COORD_BITS-1:0]   box_h;
    logic [TAG_BITS-1:0]     box_tag;
    logic                    end_of_list;
    logic                    out_valid;
    logic                    out_stall;
    logic [COORD_BITS-1:0]   out_x;
    logic [COORD_BITS-1:0]   out_y;
    logic [COORD_BITS-1:0]   out_w;
    logic [COORD_BITS-1:0]   out_h;
    logic [TAG_BITS-1:0]     out_tag;
    logic                    keep;
    logic                    final_result;
    logic [CNT_BITS-1:0]     duplicate_count;
    int                      mismatches;
    int                      results_due;
    int                      send_idle_pct;
    int                      recv_idle_pct;
    int                      sent;
    logic                    hold_off;

    box_duplicate_window_filter_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .box_x           (box_x),
        .box_y           (box_y),
        .box_w           (box_w),
        .box_h           (box_h),
        .box_tag         (box_tag),
        .end_of_list     (end_of_list),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_w           (out_w),
        .out_h           (out_h),
        .out_tag         (out_tag),
        .keep            (keep),
        .final_result    (final_result),
        .duplicate_count (duplicate_count)
    );

    bdwf_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .box_x           (box_x),
        .box_y           (box_y),
        .box_w           (box_w),
        .box_h           (box_h),
        .box_tag         (box_tag),
        .end_of_list     (end_of_list),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_w           (out_w),
        .out_h           (out_h),
        .out_tag         (out_tag),
        .keep            (keep),
        .final_result    (final_result),
        .duplicate_count (duplicate_count),
        .mismatches      (mismatches),
        .results_due     (results_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // The receiver holds off at random, or for a whole stretch while hold_off is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= hold_off || (int'($urandom % 100) < recv_idle_pct);
        end
    end

    initial
    begin : pressure
        hold_off = 1'b0;
        wait (sent >= 125);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (150)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("FAIL box_duplicate_window_filter_top");
        $finish;
    end

    function automatic box_t base_box(input int pick);
        box_t r;
        unique case (pick)
            0:       r = '{COORD_BITS'(100), COORD_BITS'(200), COORD_BITS'(40),
                           COORD_BITS'(30), TAG_BITS'(0)};
            1:       r = '{COORD_BITS'(104), COORD_BITS'(203), COORD_BITS'(44),
                           COORD_BITS'(28), TAG_BITS'(0)};
            2:       r = '{COORD_BITS'(3000), COORD_BITS'(50), COORD_BITS'(8),
                           COORD_BITS'(8), TAG_BITS'(0)};
            3:       r = '{COORD_BITS'(0), COORD_BITS'(0), COORD_BITS'(2),
                           COORD_BITS'(3), TAG_BITS'(0)};
            4:       r = '{COORD_BITS'(65532), COORD_BITS'(65530), COORD_BITS'(65533),
                           COORD_BITS'(65531), TAG_BITS'(0)};
            default: r = '{COORD_BITS'(500), COORD_BITS'(500), COORD_BITS'(500),
                           COORD_BITS'(500), TAG_BITS'(0)};
        endcase
        return r;
    endfunction

    // Most boxes are small offsets from a few anchors so that duplicates are common;
    // offsets near either end of the range wrap around.
    task automatic make_box(output box_t b);
        int   pick;
        box_t base;
        pick = int'($urandom % 10);
        if (pick >= 6)
        begin
            b.x = COORD_BITS'($urandom);
            b.y = COORD_BITS'($urandom);
            b.w = COORD_BITS'($urandom);
            b.h = COORD_BITS'($urandom);
        end
        else
        begin
            base = base_box(pick);
            b.x  = base.x + COORD_BITS'($urandom % 12) - COORD_BITS'(5);
            b.y  = base.y + COORD_BITS'($urandom % 12) - COORD_BITS'(5);
            b.w  = base.w + COORD_BITS'($urandom % 12) - COORD_BITS'(5);
            b.h  = base.h + COORD_BITS'($urandom % 12) - COORD_BITS'(5);
        end
        b.tag = TAG_BITS'(sent);
    endtask

    task automatic send_box(input box_t b, input logic eol);
        while (int'($urandom % 100) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        box_x       <= b.x;
        box_y       <= b.y;
        box_w       <= b.w;
        box_h       <= b.h;
        box_tag     <= b.tag;
        end_of_list <= eol;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Registers are written only while the block is idle and no result is pending.
    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0]     val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_stall || results_due != 0)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_list_cfg(input int idx);
        unique case (idx % 8)
            0:
            begin
                write_cfg(CFG_MATCH_TOLERANCE, CFG_BITS'(7));
                write_cfg(CFG_LOOKAHEAD, CFG_BITS'(10));
            end
            1:
            begin
                write_cfg(CFG_LOOKAHEAD, CFG_BITS'(3));
            end
            2:
            begin
                write_cfg(CFG_MATCH_TOLERANCE, CFG_BITS'(9));
                write_cfg(CFG_LOOKAHEAD, CFG_BITS'(0));
            end
            3:
            begin
                write_cfg(CFG_MATCH_TOLERANCE, CFG_BITS'(20));
                write_cfg(CFG_LOOKAHEAD, CFG_BITS'(16));
            end
            4:
            begin
                write_cfg(CFG_MATCH_TOLERANCE, CFG_BITS'(0));
                write_cfg(CFG_LOOKAHEAD, CFG_BITS'(31));
            end
            5:
            begin
                write_cfg(CFG_MATCH_TOLERANCE, CFG_BITS'(65535));
                write_cfg(CFG_LOOKAHEAD, CFG_BITS'(5));
            end
            6:
            begin
                write_cfg(CFG_MATCH_TOLERANCE, CFG_BITS'(3));
                write_cfg(CFG_LOOKAHEAD, CFG_BITS'(1));
            end
            default:
            begin
                write_cfg(CFG_MATCH_TOLERANCE, CFG_BITS'(12));
                write_cfg(CFG_LOOKAHEAD, CFG_BITS'(20));
            end
        endcase
    endtask

    initial
    begin : stimulus
        int   list_idx;
        int   len;
        int   half;
        box_t b;
        rst_n         = 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        box_x         <= '0;
        box_y         <= '0;
        box_w         <= '0;
        box_h         <= '0;
        box_tag       <= '0;
        end_of_list   <= 1'b0;
        send_idle_pct = 32;
        recv_idle_pct = 73;
        sent          = 0;
        list_idx      = 0;
        repeat (9)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);
        while (sent < N_ITEMS)
        begin
            len = 1 + int'($urandom % 20);
            if (sent + len > N_ITEMS)
            begin
                len = N_ITEMS - sent;
            end
            if (list_idx > 0)
            begin
                apply_list_cfg(list_idx);
            end
            half = len / 2;
            for (int i = 0; i < len; i++)
            begin
                if (sent >= (2 * N_ITEMS) / 3)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                else if (sent >= N_ITEMS / 3)
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 32;
                end
                // Lower the lookahead while boxes are still pending in the window.
                if ((list_idx % 8 == 3) && (i == half) && (i > 0))
                begin
                    write_cfg(CFG_LOOKAHEAD, CFG_BITS'(4));
                end
                make_box(b);
                send_box(b, i == len - 1);
                sent++;
            end
            list_idx++;
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_stall || results_due != 0)
        begin
            @(posedge clk);
        end
        repeat (5)
        begin
            @(posedge clk);
        end
        if (mismatches == 0 && results_due == 0)
        begin
            $display("PASS box_duplicate_window_filter_top");
        end
        else
        begin
            $display("FAIL box_duplicate_window_filter_top");
        end
        $finish;
    end

endmodule
